@@ design/afc_pkg.sv @@
`default_nettype none

package afc_pkg;

  // Coordinate, distance and normal component width (Q12.4 / Q1.14)
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned NORM_FRAC_W = 14;

  // Plane registers and planes tested
  localparam int unsigned PLANE_REGS = 6;
  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned NUM_CELLS  = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;
  localparam int unsigned CFG_IDX_W  = $clog2(PLANE_REGS);
  localparam int unsigned CFG_DATA_W = 4 * COORD_W;

  // Register stages inside one cell, and end-to-end latency
  localparam int unsigned CELL_STAGES = 2;
  localparam int unsigned PIPE_LAT    = CELL_STAGES * NUM_CELLS;

  // Product of a normal and a coordinate, and the sum of three of them
  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // Packed plane register: distance in the top field, normal x at the bottom
  typedef struct packed {
    logic signed [COORD_W-1:0] distance;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } afc_plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } afc_box_t;

  // What one cell hands to the next
  typedef struct packed {
    logic     valid;
    logic     vis;
    afc_box_t box;
  } afc_tok_t;

endpackage

`default_nettype wire

@@ design/afc_cell.sv @@
`default_nettype none

module afc_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire afc_pkg::afc_plane_t plane_i,
  input  wire afc_pkg::afc_tok_t   tok_i,
  output afc_pkg::afc_tok_t        tok_o
);

  // n*C + |n|*E reduces to 2*n*max for n >= 0 and 2*n*min for n < 0,
  // so pick one corner per axis and drop the common factor two.
  logic signed [afc_pkg::COORD_W-1:0] sel_x, sel_y, sel_z;
  logic signed [afc_pkg::PROD_W-1:0]  prod_x_d, prod_y_d, prod_z_d;

  logic                               s1_valid_q;
  logic                               s1_vis_q;
  afc_pkg::afc_box_t                  s1_box_q;
  logic signed [afc_pkg::PROD_W-1:0]  s1_prod_x_q, s1_prod_y_q, s1_prod_z_q;
  logic signed [afc_pkg::COORD_W-1:0] s1_dist_q;

  logic signed [afc_pkg::SUM_W-1:0]   sum;
  logic signed [afc_pkg::SUM_W-1:0]   thresh;
  logic                               pass;

  logic                               s2_valid_q;
  logic                               s2_vis_q;
  afc_pkg::afc_box_t                  s2_box_q;

  always_comb begin
    sel_x    = plane_i.nx[afc_pkg::COORD_W-1] ? tok_i.box.min_x : tok_i.box.max_x;
    sel_y    = plane_i.ny[afc_pkg::COORD_W-1] ? tok_i.box.min_y : tok_i.box.max_y;
    sel_z    = plane_i.nz[afc_pkg::COORD_W-1] ? tok_i.box.min_z : tok_i.box.max_z;
    prod_x_d = plane_i.nx * sel_x;
    prod_y_d = plane_i.ny * sel_y;
    prod_z_d = plane_i.nz * sel_z;
  end

  // Stage one: products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_vis_q    <= tok_i.vis;
    s1_box_q    <= tok_i.box;
    s1_prod_x_q <= prod_x_d;
    s1_prod_y_q <= prod_y_d;
    s1_prod_z_q <= prod_z_d;
    s1_dist_q   <= plane_i.distance;
  end

  // Stage two: sum and compare against distance scaled to the product format
  always_comb begin
    sum = $signed({{2{s1_prod_x_q[afc_pkg::PROD_W-1]}}, s1_prod_x_q})
        + $signed({{2{s1_prod_y_q[afc_pkg::PROD_W-1]}}, s1_prod_y_q})
        + $signed({{2{s1_prod_z_q[afc_pkg::PROD_W-1]}}, s1_prod_z_q});
    thresh = $signed({{(afc_pkg::SUM_W - afc_pkg::COORD_W - afc_pkg::NORM_FRAC_W)
                       {s1_dist_q[afc_pkg::COORD_W-1]}},
                      s1_dist_q, {afc_pkg::NORM_FRAC_W{1'b0}}});
    pass = (sum >= thresh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_vis_q <= s1_vis_q & pass;
    s2_box_q <= s1_box_q;
  end

  assign tok_o.valid = s2_valid_q;
  assign tok_o.vis   = s2_vis_q;
  assign tok_o.box   = s2_box_q;

  // A box rejected upstream never comes back as visible.
  a_vis_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_vis_q |=> !s2_vis_q)
    else $error("afc_cell: rejected box turned visible");

  // An all-zero plane always passes.
  a_zero_plane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_prod_x_q == '0 && s1_prod_y_q == '0 && s1_prod_z_q == '0
      && s1_dist_q == '0 |=> s2_vis_q == $past(s1_vis_q))
    else $error("afc_cell: zero plane rejected a box");

  // Valid walks through the stage-one and then the stage-two register.
  a_valid_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid |=> ##1 s2_valid_q)
    else $error("afc_cell: token lost inside cell");

endmodule

`default_nettype wire

@@ design/aabb_frustum_cull.sv @@
`default_nettype none

// Box-versus-frustum visibility test. Each start transfer carries one box
// (min and max corners, signed Q12.4) and yields exactly one visible_o
// result, flagged by done_o for a single cycle once the box leaves the
// last cell of the chain. The receiver cannot stall: take the
// result in the cycle done_o is high or lose it. busy stays low, so a
// new box may be issued every cycle. The test runs down a chain of cells,
// one per plane; each cell is fed its plane, forms the three normal-times-
// corner products in its first stage and the sum and distance compare in
// its second, then passes the box and the running verdict to the next
// cell. The latency is set by that chain: two registers per plane.
// Planes are written through the cfg port (index 0 near, 1 far, 2 top,
// 3 bottom, 4 left, 5 right; bits 15:0 normal x, 31:16 normal y, 47:32
// normal z in Q1.14, 63:48 distance in Q12.4); writes to other indices
// are dropped. Reset clears all planes, so every box is visible until
// planes are loaded. Write planes only while no box is in flight.

module aabb_frustum_cull (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Box command
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [afc_pkg::COORD_W-1:0]   min_x_i,
  input  wire logic signed [afc_pkg::COORD_W-1:0]   min_y_i,
  input  wire logic signed [afc_pkg::COORD_W-1:0]   min_z_i,
  input  wire logic signed [afc_pkg::COORD_W-1:0]   max_x_i,
  input  wire logic signed [afc_pkg::COORD_W-1:0]   max_y_i,
  input  wire logic signed [afc_pkg::COORD_W-1:0]   max_z_i,
  // Result strobe
  output logic                                      done_o,
  output logic                                      visible_o,
  // Plane register writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [afc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [afc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  afc_pkg::afc_plane_t plane_q [afc_pkg::PLANE_REGS];
  afc_pkg::afc_tok_t   tok [afc_pkg::NUM_CELLS+1];
  logic                accept;

  // The chain never blocks.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // Plane registers: hold until a matching index transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < afc_pkg::PLANE_REGS; i++) begin
        plane_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < afc_pkg::PLANE_REGS; i++) begin
        if (cfg_valid_i && cfg_ready_o && cfg_index_i == afc_pkg::CFG_IDX_W'(i)) begin
          plane_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Head of the chain: the box enters as visible, each cell may clear it
  assign tok[0].valid     = accept;
  assign tok[0].vis       = 1'b1;
  assign tok[0].box.min_x = min_x_i;
  assign tok[0].box.min_y = min_y_i;
  assign tok[0].box.min_z = min_z_i;
  assign tok[0].box.max_x = max_x_i;
  assign tok[0].box.max_y = max_y_i;
  assign tok[0].box.max_z = max_z_i;

  for (genvar g = 0; g < afc_pkg::NUM_CELLS; g++) begin : g_cell
    afc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .plane_i (plane_q[g]),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  // Tail of the chain drives the result strobe
  assign done_o    = tok[afc_pkg::NUM_CELLS].valid;
  assign visible_o = tok[afc_pkg::NUM_CELLS].vis;

  // Every accepted box comes out after the fixed latency.
  a_lat_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(afc_pkg::PIPE_LAT) done_o)
    else $error("aabb_frustum_cull: result missing");

  // No result without a box accepted at the head of the chain.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, afc_pkg::PIPE_LAT))
    else $error("aabb_frustum_cull: spurious result");

  // Both the box and the plane channels are always open.
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("aabb_frustum_cull: channel blocked");

endmodule

`default_nettype wire
